// ===== hdl/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// widths of the position stamps and window register, per-cycle cell control
// ----------------------------------------------------------------------------
package swm_pkg;

	// position stamps wrap at this width
	localparam int POS_W = 16;

	// window length register
	localparam int WINDOW_CFG_W = 7;
	localparam logic [WINDOW_CFG_W-1:0] WINDOW_RESET = 7'd4;

	// control broadcast to every cell of the queue each cycle
	typedef struct packed {
		logic             shift;  // move every entry one cell toward the front
		logic             load;   // a sample beat is taken this cycle
		logic             start;  // drop the whole queue before the sample
		logic [POS_W-1:0] pos;    // position stamp of the incoming sample
	} swm_step_t;

endpackage

// ===== hdl/sliding_window_maximum.sv =====
`timescale 1ns / 1ps
// once the window has filled, a result beat appears in the cycle after its sample beat is accepted
// throughput: one sample beat per cycle while the window length is unchanged and result beats are taken
// after the window is shortened, each extra expired front entry costs one
// chain shift while the next beat is held off
// reset: queue emptied, position and fill count zero, window length 4
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over the last window_size samples
// a chain of cells holds the monotonic queue, front in cell 0; every cycle
// each cell looks at its neighbors, step and sample to evict, drop, append
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
	parameter int WINDOW_DEPTH = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// window length register
	input  logic                                 cfg_write_en,
	input  logic [swm_pkg::WINDOW_CFG_W-1:0]     cfg_write_data,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
	input  logic                                 sequence_start,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       window_max
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [swm_pkg::POS_W-1:0] DEPTH_POS = swm_pkg::POS_W'(WINDOW_DEPTH);
	localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

	// configuration and sequence state
	logic [swm_pkg::WINDOW_CFG_W-1:0] window_size_q;
	logic [swm_pkg::POS_W-1:0]        pos_cnt_q;
	logic [FILL_W-1:0]                fill_q;

	// output register
	logic                             out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]   window_max_q;

	// chain taps; the extra slot past the last cell reads as empty
	logic                             cell_valid [WINDOW_DEPTH+1];
	logic [swm_pkg::POS_W-1:0]        cell_pos   [WINDOW_DEPTH+1];
	logic signed [SAMPLE_WIDTH-1:0]   cell_value [WINDOW_DEPTH+1];
	logic                             keep_chain [WINDOW_DEPTH+1];

	swm_pkg::swm_step_t               step;

	logic [swm_pkg::POS_W-1:0]        win_pos;
	logic [FILL_W-1:0]                win_fill;
	logic [swm_pkg::POS_W-1:0]        age0;
	logic [swm_pkg::POS_W-1:0]        age1;
	logic                             old0;
	logic                             old1;
	logic                             purge;
	logic                             accept;
	logic [FILL_W-1:0]                fill_base;
	logic [FILL_W-1:0]                fill_nxt;
	logic signed [SAMPLE_WIDTH-1:0]   front_nxt;

	// effective window: zero acts as one, clipped to the queue depth
	always_comb begin
		win_pos = swm_pkg::POS_W'(window_size_q);
		if (window_size_q == '0) begin
			win_pos = swm_pkg::POS_W'(1);
		end else if (win_pos > DEPTH_POS) begin
			win_pos = DEPTH_POS;
		end
		win_fill = win_pos[FILL_W-1:0];
	end

	// age of the two front entries against the stamp the next sample gets
	assign age0 = pos_cnt_q - cell_pos[0];
	assign age1 = pos_cnt_q - cell_pos[1];
	assign old0 = cell_valid[0] && (age0 >= win_pos);
	assign old1 = cell_valid[1] && (age1 >= win_pos);

	// more than one expired entry only follows a shorter window: clear the
	// surplus one shift per cycle while a sample beat waits, holding it off;
	// with no beat waiting the queue is left alone so a later window write
	// still ages the entries against its own length
	assign purge = old0 && old1 && in_valid;

	// a sample beat is taken while no purge runs and the result slot is free or draining
	assign in_ready = !purge && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		step.shift = purge || (accept && !sequence_start && old0);
		step.load  = accept;
		step.start = accept && sequence_start;
		step.pos   = sequence_start ? '0 : pos_cnt_q;
	end

	// the chain itself
	assign cell_valid[WINDOW_DEPTH] = 1'b0;
	assign cell_pos[WINDOW_DEPTH]   = '0;
	assign cell_value[WINDOW_DEPTH] = '0;
	// nothing ahead of the front, so cell 0 takes the sample if it drops
	assign keep_chain[0]            = 1'b1;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		swm_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (step),
			.sample_value(sample_value),
			.right_valid (cell_valid[i+1]),
			.right_pos   (cell_pos[i+1]),
			.right_value (cell_value[i+1]),
			.left_keep   (keep_chain[i]),
			.keep        (keep_chain[i+1]),
			.valid       (cell_valid[i]),
			.pos         (cell_pos[i]),
			.value       (cell_value[i])
		);
	end

	// front after this beat: the surviving head, or the sample if all dropped
	always_comb begin
		if (keep_chain[1]) begin
			front_nxt = step.shift ? cell_value[1] : cell_value[0];
		end else begin
			front_nxt = sample_value;
		end
	end

	// fill count saturates at the depth
	assign fill_base = sequence_start ? '0 : fill_q;
	assign fill_nxt  = (fill_base < DEPTH_FILL) ? fill_base + FILL_W'(1) : fill_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swm_pkg::WINDOW_RESET;
		end else if (cfg_write_en) begin
			window_size_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			pos_cnt_q <= step.pos + swm_pkg::POS_W'(1);
			fill_q    <= fill_nxt;
		end
	end

	// result beat only once the window has filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= (fill_nxt >= win_fill);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_max_q <= front_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	// the two front entries stay in strictly decreasing order
	a_front_order: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cell_valid[0] && (cell_value[0] > cell_value[1])))
		else $error("queue order broken at the front");

	// after a sample beat the head is present and still inside the window
	a_head_age: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cell_valid[0] && ((pos_cnt_q - cell_pos[0]) <= $past(win_pos))))
		else $error("queue head missing or expired after a sample beat");

	// a waiting result beat blocks the sample side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !in_ready)
		else $error("sample taken while result slot is full");

endmodule

// ===== hdl/swm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one entry of the monotonic queue
// holds a value and its position, takes its right neighbor on a shift and
// either keeps its entry, takes the new sample, or empties itself
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::swm_step_t             ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
	input  logic                           right_valid,
	input  logic [swm_pkg::POS_W-1:0]      right_pos,
	input  logic signed [SAMPLE_WIDTH-1:0] right_value,
	input  logic                           left_keep,
	output logic                           keep,
	output logic                           valid,
	output logic [swm_pkg::POS_W-1:0]      pos,
	output logic signed [SAMPLE_WIDTH-1:0] value
);

	logic                           valid_q;
	logic [swm_pkg::POS_W-1:0]      pos_q;
	logic signed [SAMPLE_WIDTH-1:0] value_q;

	logic                           sh_valid;
	logic [swm_pkg::POS_W-1:0]      sh_pos;
	logic signed [SAMPLE_WIDTH-1:0] sh_value;
	logic                           take;

	// entry after the front eviction shift
	always_comb begin
		sh_valid = ctl.start ? 1'b0 : (ctl.shift ? right_valid : valid_q);
		sh_pos   = ctl.shift ? right_pos : pos_q;
		sh_value = ctl.shift ? right_value : value_q;
	end

	// survives only if strictly above the new sample; ties go to the newer one
	assign keep = sh_valid && (!ctl.load || (sh_value > sample_value));
	// first cell that does not survive takes the sample
	assign take = ctl.load && !keep && left_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= keep || take;
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			pos_q   <= sh_pos;
			value_q <= sh_value;
		end else if (take) begin
			pos_q   <= ctl.pos;
			value_q <= sample_value;
		end
	end

	assign valid = valid_q;
	assign pos   = pos_q;
	assign value = value_q;

endmodule
